>>> rtl/bmsoc_pkg.sv
package bmsoc_pkg;

    // fixed field widths
    localparam int SAMPLE_W = 12;
    localparam int MV_W     = 14;
    localparam int PCT_W    = 8;
    localparam int GOOD_W   = 4;
    localparam int FS_W     = 12;
    localparam int DIV_W    = 3;
    localparam int CFG_W    = 14;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_ENABLE     = 2'd0,
        CFG_FULL_SCALE = 2'd1,
        CFG_DIVIDER    = 2'd2,
        CFG_THRESHOLD  = 2'd3
    } cfg_reg_t;

    // reset values of the registers
    localparam logic [FS_W-1:0]  FULL_SCALE_RST = 12'd3100;
    localparam logic [DIV_W-1:0] DIVIDER_RST    = 3'd2;
    localparam logic [MV_W-1:0]  THRESHOLD_RST  = 14'd2500;

    // scaling constants
    localparam logic [SAMPLE_W-1:0] RAW_FULL_CODE = 12'd4095;
    localparam logic [MV_W-1:0]     MV_MAX        = 14'd16383;

    // li-ion discharge curve, highest point first
    localparam int SOC_POINTS = 10;
    localparam logic [12:0] SOC_MV [SOC_POINTS] = '{
        13'd4200, 13'd4100, 13'd4000, 13'd3900, 13'd3800,
        13'd3700, 13'd3600, 13'd3500, 13'd3400, 13'd3300
    };
    localparam logic [6:0] SOC_PCT [SOC_POINTS] = '{
        7'd100, 7'd90, 7'd80, 7'd65, 7'd50, 7'd35, 7'd20, 7'd10, 7'd5, 7'd0
    };

    // floor(p / 100) = (p * 5243) >> 19 for the small products seen here
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;

    localparam logic signed [PCT_W-1:0] PCT_ABSENT = -8'sd1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                read_ok;
    } in_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0]     median_raw;
        logic [MV_W-1:0]         vbat_mv;
        logic signed [PCT_W-1:0] charge_percent;
        logic                    present;
        logic [GOOD_W-1:0]       good_count;
    } out_t;

    // settings used by the scaling pipeline
    typedef struct packed {
        logic [FS_W-1:0]  full_scale_mv;
        logic [DIV_W-1:0] divider_ratio;
        logic [MV_W-1:0]  present_threshold_mv;
    } scale_cfg_t;

    // insert command broadcast along the chain
    typedef struct packed {
        logic                insert;
        logic [SAMPLE_W-1:0] value;
    } sort_op_t;

    // hand-off between neighbouring cells
    typedef struct packed {
        logic                gt;
        logic [SAMPLE_W-1:0] value;
    } link_t;

    // poll summary from the sorter to the scaling pipeline
    typedef struct packed {
        logic [SAMPLE_W-1:0] median;
        logic [GOOD_W-1:0]   count;
    } poll_t;

endpackage

>>> rtl/battery_median_soc_monitor.sv
// Battery monitor: takes one ADC read per cycle (valid/stall), groups READS_PER_POLL
// reads into a poll and keeps the good reads of the poll sorted in a chain of
// READS_PER_POLL compare-and-shift cells, one insertion per cycle. After the last
// read of a poll with at least one good read, the median is captured at the edge
// that accepts that read and passes through a five-stage scaling pipeline (multiply
// by full scale, divide by 4095, divider scaling and threshold, curve segment lookup,
// interpolation); the result is offered from the last stage's output register. The
// next poll streams in meanwhile; input stalls only while a captured poll cannot
// enter the full pipeline. Reads are accepted and ignored while disabled.
module battery_median_soc_monitor
    import bmsoc_pkg::*;
#(
    parameter int READS_PER_POLL = 9,
    parameter int SAMPLE_BITS    = 12
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_t              in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_t             out_data,
    input  logic             cfg_write,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int MASK_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((33'(1) << MASK_BITS) - 33'(1));

    logic             enable_reg;
    logic [FS_W-1:0]  full_scale_reg;
    logic [DIV_W-1:0] divider_reg;
    logic [MV_W-1:0]  threshold_reg;
    scale_cfg_t       scale_cfg;
    logic             cap_valid;
    logic             cap_ready;
    poll_t            cap;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b0;
            full_scale_reg <= FULL_SCALE_RST;
            divider_reg    <= DIVIDER_RST;
            threshold_reg  <= THRESHOLD_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_ENABLE:     enable_reg     <= cfg_data[0];
                CFG_FULL_SCALE: full_scale_reg <= cfg_data[FS_W-1:0];
                CFG_DIVIDER:    divider_reg    <= cfg_data[DIV_W-1:0];
                CFG_THRESHOLD:  threshold_reg  <= cfg_data[MV_W-1:0];
            endcase
        end
    end

    assign scale_cfg.full_scale_mv        = full_scale_reg;
    assign scale_cfg.divider_ratio        = divider_reg;
    assign scale_cfg.present_threshold_mv = threshold_reg;

    // sorting chain and poll counters
    bmsoc_sorter #(
        .READS_PER_POLL (READS_PER_POLL)
    ) u_sorter (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (enable_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (in_data.sample & SAMPLE_MASK),
        .read_ok   (in_data.read_ok),
        .cap_valid (cap_valid),
        .cap_ready (cap_ready),
        .cap       (cap)
    );

    // millivolt and charge pipeline
    bmsoc_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (scale_cfg),
        .cap_valid (cap_valid),
        .cap_ready (cap_ready),
        .cap       (cap),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

>>> rtl/bmsoc_cell.sv
module bmsoc_cell
    import bmsoc_pkg::*;
#(
    parameter int CNT_W = 4,
    parameter int INDEX = 0
)
(
    input  logic                clk,
    input  sort_op_t            op,
    input  logic [CNT_W-1:0]    fill,
    input  link_t               prev,
    output link_t               next,
    output logic [SAMPLE_W-1:0] val_next
);

    logic [SAMPLE_W-1:0] val_reg;
    logic                empty;
    logic                gt;

    // an empty cell counts as larger than any sample
    assign empty = (fill <= CNT_W'(INDEX));
    assign gt    = empty || (val_reg > op.value);

    // hold when nothing is inserted, else take the left neighbour's value, take the new sample or keep its own
    always_comb
    begin
        if (!op.insert)
        begin
            val_next = val_reg;
        end
        else if (prev.gt)
        begin
            val_next = prev.value;
        end
        else if (gt)
        begin
            val_next = op.value;
        end
        else
        begin
            val_next = val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.insert)
        begin
            val_reg <= val_next;
        end
    end

    assign next.gt    = gt;
    assign next.value = val_reg;

endmodule

>>> rtl/bmsoc_sorter.sv
module bmsoc_sorter
    import bmsoc_pkg::*;
#(
    parameter int READS_PER_POLL = 9
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                enable,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic                read_ok,
    output logic                cap_valid,
    input  logic                cap_ready,
    output poll_t               cap
);

    localparam int CNT_W = $clog2(READS_PER_POLL + 1);
    localparam int IDX_W = (READS_PER_POLL > 1) ? $clog2(READS_PER_POLL) : 1;

    logic [CNT_W-1:0]    reads_reg;
    logic [CNT_W-1:0]    reads_next;
    logic [CNT_W-1:0]    good_reg;
    logic [CNT_W-1:0]    good_next;
    logic [CNT_W-1:0]    good_inc;
    logic [CNT_W-1:0]    half;
    logic [IDX_W-1:0]    mid_idx;
    logic                cap_valid_reg;
    logic                cap_valid_next;
    poll_t               cap_reg;
    poll_t               cap_next;
    logic                step;
    logic                take;
    logic                last;
    sort_op_t            op;
    link_t               links [READS_PER_POLL+1];
    logic [SAMPLE_W-1:0] cell_next [READS_PER_POLL];

    // transfer control
    assign in_stall = cap_valid_reg && !cap_ready;
    assign step     = in_valid && !in_stall && enable;
    assign take     = step && read_ok && (good_reg < CNT_W'(READS_PER_POLL));
    assign last     = step && (reads_reg == CNT_W'(READS_PER_POLL - 1));
    assign good_inc = good_reg + CNT_W'(take);

    assign op.insert = take;
    assign op.value  = sample;

    // chain of sorting cells, ascending from cell 0
    assign links[0] = '{gt: 1'b0, value: '0};

    for (genvar i = 0; i < READS_PER_POLL; i++)
    begin : g_cell
        bmsoc_cell #(
            .CNT_W (CNT_W),
            .INDEX (i)
        ) u_cell (
            .clk      (clk),
            .op       (op),
            .fill     (good_reg),
            .prev     (links[i]),
            .next     (links[i+1]),
            .val_next (cell_next[i])
        );
    end

    // median of the store as it stands after this read
    assign half    = good_inc >> 1;
    assign mid_idx = half[IDX_W-1:0];

    // poll counters
    always_comb
    begin
        reads_next = reads_reg;
        good_next  = good_reg;
        if (last)
        begin
            reads_next = '0;
            good_next  = '0;
        end
        else if (step)
        begin
            reads_next = reads_reg + CNT_W'(1);
            good_next  = good_inc;
        end
    end

    // poll summary register
    always_comb
    begin
        cap_valid_next = cap_valid_reg && !cap_ready;
        cap_next       = cap_reg;
        if (last && (good_inc != '0))
        begin
            cap_valid_next = 1'b1;
            cap_next.median = cell_next[mid_idx];
            cap_next.count  = GOOD_W'(good_inc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reads_reg     <= '0;
            good_reg      <= '0;
            cap_valid_reg <= 1'b0;
        end
        else
        begin
            reads_reg     <= reads_next;
            good_reg      <= good_next;
            cap_valid_reg <= cap_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cap_reg <= cap_next;
    end

    assign cap_valid = cap_valid_reg;
    assign cap       = cap_reg;

endmodule

>>> rtl/bmsoc_scale.sv
module bmsoc_scale
    import bmsoc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  scale_cfg_t cfg,
    input  logic       cap_valid,
    output logic       cap_ready,
    input  poll_t      cap,
    output logic       out_valid,
    input  logic       out_stall,
    output out_t       out_data
);

    // stage valids and ready chain
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic r1, r2, r3, r4, r5;

    // stage payloads
    poll_t              p1_reg, p2_reg, p3_reg, p4_reg;
    logic [23:0]        prod_reg;
    logic [11:0]        q_reg;
    logic [MV_W-1:0]    mv3_reg, mv4_reg;
    logic               pres3_reg, pres4_reg;
    logic [6:0]         base_reg;
    logic [10:0]        frac_reg;
    out_t               out_reg;

    // combinational values
    logic [11:0]        q_est;
    logic [12:0]        rem;
    logic [11:0]        q_next;
    logic [14:0]        mv_wide;
    logic [MV_W-1:0]    mv_next;
    logic [6:0]         base_next;
    logic [6:0]         off_next;
    logic [4:0]         dpct_next;
    logic [MV_W-1:0]    diff;
    logic [23:0]        quot_wide;
    logic [6:0]         pct_next;

    assign r5        = !v5_reg || !out_stall;
    assign r4        = !v4_reg || r5;
    assign r3        = !v3_reg || r4;
    assign r2        = !v2_reg || r3;
    assign r1        = !v1_reg || r2;
    assign cap_ready = r1;

    // divide by 4095: estimate by 4096, remainder decides one correction
    assign q_est  = prod_reg[23:12];
    assign rem    = {1'b0, prod_reg[11:0]} + {1'b0, q_est};
    assign q_next = q_est + 12'(rem >= {1'b0, RAW_FULL_CODE});

    // divider scaling with saturation
    assign mv_wide = q_reg * cfg.divider_ratio;
    assign mv_next = (mv_wide > {1'b0, MV_MAX}) ? MV_MAX : mv_wide[MV_W-1:0];

    // curve segment lookup, the higher segment wins on a shared point
    always_comb
    begin
        base_next = '0;
        off_next  = '0;
        dpct_next = '0;
        diff      = '0;
        if (mv3_reg >= MV_W'(SOC_MV[0]))
        begin
            base_next = SOC_PCT[0];
        end
        else if (mv3_reg > MV_W'(SOC_MV[SOC_POINTS-1]))
        begin
            for (int i = SOC_POINTS - 2; i >= 0; i--)
            begin
                if ((mv3_reg <= MV_W'(SOC_MV[i])) && (mv3_reg >= MV_W'(SOC_MV[i+1])))
                begin
                    diff      = mv3_reg - MV_W'(SOC_MV[i+1]);
                    base_next = SOC_PCT[i+1];
                    off_next  = diff[6:0];
                    dpct_next = 5'(SOC_PCT[i] - SOC_PCT[i+1]);
                end
            end
        end
    end

    // interpolation step divided by the 100 mV segment width
    assign quot_wide = (24'(frac_reg) * 24'(DIV100_MUL)) >> DIV100_SHIFT;
    assign pct_next  = base_reg + quot_wide[6:0];

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (r1)
            begin
                v1_reg <= cap_valid;
            end
            if (r2)
            begin
                v2_reg <= v1_reg;
            end
            if (r3)
            begin
                v3_reg <= v2_reg;
            end
            if (r4)
            begin
                v4_reg <= v3_reg;
            end
            if (r5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (r1)
        begin
            p1_reg   <= cap;
            prod_reg <= cap.median * cfg.full_scale_mv;
        end
        if (r2)
        begin
            p2_reg <= p1_reg;
            q_reg  <= q_next;
        end
        if (r3)
        begin
            p3_reg    <= p2_reg;
            mv3_reg   <= mv_next;
            pres3_reg <= (mv_next >= cfg.present_threshold_mv);
        end
        if (r4)
        begin
            p4_reg    <= p3_reg;
            mv4_reg   <= mv3_reg;
            pres4_reg <= pres3_reg;
            base_reg  <= base_next;
            frac_reg  <= off_next * dpct_next;
        end
        if (r5)
        begin
            out_reg.median_raw     <= p4_reg.median;
            out_reg.vbat_mv        <= mv4_reg;
            out_reg.present        <= pres4_reg;
            out_reg.good_count     <= p4_reg.count;
            out_reg.charge_percent <= pres4_reg ? $signed({1'b0, pct_next}) : PCT_ABSENT;
        end
    end

    assign out_valid = v5_reg;
    assign out_data  = out_reg;

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import bmsoc_pkg::*;

    localparam int READS       = 9;
    localparam int SETTLE_GAP  = 12;
    localparam int HOLD_LEN    = 400;
    localparam int CYCLE_LIMIT = 250000;
    localparam int DRAIN_LIMIT = 5000;

    // li-ion curve, highest point first
    localparam int CURVE_MV [10] = '{4200, 4100, 4000, 3900, 3800, 3700, 3600, 3500, 3400, 3300};
    localparam int CURVE_PCT [10] = '{100, 90, 80, 65, 50, 35, 20, 10, 5, 0};

    typedef enum {OP_READ, OP_WRITE, OP_SETTLE, OP_PACE, OP_HOLD} step_kind_t;

    typedef struct {
        step_kind_t       kind;
        in_t              rd;
        cfg_reg_t         idx;
        logic [CFG_W-1:0] val;
        int               tx_pct;
        int               rx_pct;
    } step_t;

    logic             clk;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    in_t              in_data = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    out_t             out_data;
    logic             cfg_write = 1'b0;
    cfg_reg_t         cfg_index = CFG_ENABLE;
    logic [CFG_W-1:0] cfg_data = '0;

    // stimulus schedule and pacing
    step_t step_q[$];
    int    tx_idle_pct = 0;
    int    rx_idle_pct = 0;
    int    hold_seq = 0;
    int    hold_seen = 0;
    int    hold_left = 0;
    bit    read_taken = 1'b0;
    bit    settling = 1'b0;
    int    settle_left = 0;

    // monitor model state
    bit          mon_enable = 1'b0;
    int unsigned fs_mv = 3100;
    int unsigned div_ratio = 2;
    int unsigned thr_mv = 2500;
    int unsigned poll_store [READS];
    int unsigned poll_good = 0;
    int unsigned poll_reads = 0;
    out_t        due_readings[$];

    int cycle_count = 0;
    int mismatches = 0;

    battery_median_soc_monitor i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch at cycle %0d: %s got %0d, expected %0d",
                 cycle_count, what, got, want);
    endtask

    // charge level along the discharge curve, truncating inside a segment
    function automatic int soc_from_mv(input int mv);
        int  pct;
        int  k;
        bit  hit;
        pct = 0;
        hit = 1'b0;
        if (mv >= CURVE_MV[0])
            pct = 100;
        else if (mv > CURVE_MV[9])
        begin
            for (k = 0; k < 9 && !hit; k++)
            begin
                if (mv <= CURVE_MV[k] && mv >= CURVE_MV[k+1])
                begin
                    pct = CURVE_PCT[k+1] + (mv - CURVE_MV[k+1]) * (CURVE_PCT[k] - CURVE_PCT[k+1])
                          / (CURVE_MV[k] - CURVE_MV[k+1]);
                    hit = 1'b1;
                end
            end
        end
        return pct;
    endfunction

    // sorted insertion of one read, reading out at the end of a poll
    function automatic void predict_poll(input in_t rd);
        int unsigned pos;
        int unsigned n;
        int unsigned mv;
        out_t        r;
        if (!mon_enable)
            return;
        if (rd.read_ok && poll_good < READS)
        begin
            pos = poll_good;
            while (pos > 0 && poll_store[pos-1] > rd.sample)
            begin
                poll_store[pos] = poll_store[pos-1];
                pos--;
            end
            poll_store[pos] = rd.sample;
            poll_good++;
        end
        poll_reads++;
        if (poll_reads < READS)
            return;
        n = poll_good;
        poll_reads = 0;
        poll_good = 0;
        if (n == 0)
            return;
        mv = poll_store[n/2] * fs_mv / 4095 * div_ratio;
        if (mv > 16383)
            mv = 16383;
        r.median_raw = SAMPLE_W'(poll_store[n/2]);
        r.vbat_mv = MV_W'(mv);
        r.present = (mv >= thr_mv);
        r.charge_percent = r.present ? PCT_W'(soc_from_mv(mv)) : PCT_ABSENT;
        r.good_count = GOOD_W'(n);
        due_readings.push_back(r);
    endfunction

    // schedule builders
    task automatic push_read(input int unsigned sample, input bit ok);
        step_t s;
        s.kind = OP_READ;
        s.rd.sample = SAMPLE_W'(sample);
        s.rd.read_ok = ok;
        step_q.push_back(s);
    endtask

    task automatic push_write(input cfg_reg_t idx, input int unsigned val);
        step_t s;
        s.kind = OP_WRITE;
        s.idx = idx;
        s.val = CFG_W'(val);
        step_q.push_back(s);
    endtask

    task automatic push_simple(input step_kind_t kind, input int tx_pct, input int rx_pct);
        step_t s;
        s.kind = kind;
        s.tx_pct = tx_pct;
        s.rx_pct = rx_pct;
        step_q.push_back(s);
    endtask

    // random reads; band_pct steers samples onto the curve breakpoints
    task automatic random_reads(input int n, input int band_pct);
        int          k;
        int          j;
        int unsigned s;
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(49) == 0)
            begin
                // a failed stretch long enough to empty a whole poll
                for (j = 0; j < 2 * READS - 1; j++)
                    push_read($urandom_range(4095), 1'b0);
            end
            if ($urandom_range(99) < band_pct)
            begin
                if ($urandom_range(1) == 1)
                    s = 3299 + 100 * $urandom_range(9) + $urandom_range(2);
                else
                    s = $urandom_range(4250, 3250);
            end
            else
                s = $urandom_range(4095);
            push_read(s, $urandom_range(99) < 85);
        end
    endtask

    task automatic run_phase(input int unsigned fs, input int unsigned dv,
                             input int unsigned thr, input int n, input int band_pct);
        push_simple(OP_SETTLE, 0, 0);
        push_write(CFG_FULL_SCALE, fs);
        push_write(CFG_DIVIDER, dv);
        push_write(CFG_THRESHOLD, thr);
        random_reads(n, band_pct);
    endtask

    // driver: one transfer offered at a time, inputs move on the falling edge
    always @(negedge clk)
    begin : drive_proc
        logic  nxt_valid;
        in_t   nxt_data;
        logic  nxt_write;
        step_t s;
        nxt_valid = in_valid && !read_taken;
        nxt_data = in_data;
        nxt_write = 1'b0;
        if (rst_n && !nxt_valid)
        begin
            if (settle_left > 0)
                settle_left--;
            else if (settling)
            begin
                if (due_readings.size() == 0)
                begin
                    settling = 1'b0;
                    settle_left = SETTLE_GAP;
                end
            end
            else if (step_q.size() > 0)
            begin
                s = step_q[0];
                case (s.kind)
                    OP_READ:
                    begin
                        if ($urandom_range(99) >= tx_idle_pct)
                        begin
                            void'(step_q.pop_front());
                            nxt_valid = 1'b1;
                            nxt_data = s.rd;
                            read_taken = 1'b0;
                        end
                    end
                    OP_WRITE:
                    begin
                        void'(step_q.pop_front());
                        nxt_write = 1'b1;
                        cfg_index <= s.idx;
                        cfg_data <= s.val;
                    end
                    OP_SETTLE:
                    begin
                        void'(step_q.pop_front());
                        settling = 1'b1;
                    end
                    OP_PACE:
                    begin
                        void'(step_q.pop_front());
                        tx_idle_pct = s.tx_pct;
                        rx_idle_pct <= s.rx_pct;
                    end
                    OP_HOLD:
                    begin
                        void'(step_q.pop_front());
                        hold_seq <= hold_seq + 1;
                    end
                    default: ;
                endcase
            end
        end
        in_valid <= nxt_valid;
        in_data <= nxt_data;
        cfg_write <= nxt_write;
    end

    // receiver stall: random, or a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen = hold_seq;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // monitor: register writes, accepted reads and accepted results
    always @(posedge clk)
    begin : watch_proc
        out_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("battery_median_soc_monitor verification failed");
            $finish;
        end
        else if (rst_n)
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_ENABLE:     mon_enable = cfg_data[0];
                    CFG_FULL_SCALE: fs_mv = cfg_data[FS_W-1:0];
                    CFG_DIVIDER:    div_ratio = cfg_data[DIV_W-1:0];
                    CFG_THRESHOLD:  thr_mv = cfg_data[MV_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (due_readings.size() == 0)
                    flag_mismatch("unexpected result, median_raw", out_data.median_raw, -1);
                else
                begin
                    want = due_readings.pop_front();
                    if (out_data.median_raw !== want.median_raw)
                        flag_mismatch("median_raw", out_data.median_raw, want.median_raw);
                    if (out_data.vbat_mv !== want.vbat_mv)
                        flag_mismatch("vbat_mv", out_data.vbat_mv, want.vbat_mv);
                    if (out_data.charge_percent !== want.charge_percent)
                        flag_mismatch("charge_percent", $signed(out_data.charge_percent),
                                      $signed(want.charge_percent));
                    if (out_data.present !== want.present)
                        flag_mismatch("present", out_data.present, want.present);
                    if (out_data.good_count !== want.good_count)
                        flag_mismatch("good_count", out_data.good_count, want.good_count);
                end
            end
            if (in_valid && !in_stall)
            begin
                read_taken = 1'b1;
                predict_poll(in_data);
            end
        end
    end

    initial
    begin : stim_proc
        int k;
        int waited;
        for (k = 0; k < READS; k++)
            poll_store[k] = 0;

        // reads while still disabled after reset are dropped
        push_simple(OP_PACE, 0, 0);
        push_read(4095, 1'b1);
        push_read(0, 1'b1);
        push_simple(OP_SETTLE, 0, 0);
        push_write(CFG_ENABLE, 1);
        // a poll of failed reads only
        for (k = 0; k < READS; k++)
            push_read((k % 2) ? 4095 : 0, 1'b0);
        // a full poll of good reads at the extremes, reset scaling
        push_read(4095, 1'b1);
        push_read(0, 1'b1);
        push_read(2048, 1'b1);
        push_read(4095, 1'b1);
        push_read(0, 1'b1);
        push_read(1, 1'b1);
        push_read(4094, 1'b1);
        push_read(3000, 1'b1);
        push_read(2047, 1'b1);
        // a single good read in the poll
        for (k = 0; k < READS; k++)
            push_read(k == 4 ? 4095 : 12'h555, k == 4);

        // sender idles often, receiver mostly stalls
        push_simple(OP_PACE, 26, 68);
        run_phase(3100, 2, 2500, 110, 0);
        run_phase(4095, 1, 0, 110, 80);
        run_phase(1000, 4, 3000, 110, 10);
        run_phase(3300, 4, 13200, 110, 10);

        // the other way round, with the odd register corners
        push_simple(OP_PACE, 68, 26);
        run_phase(0, 3, 0, 110, 0);
        run_phase(4095, 7, 16383, 110, 0);
        run_phase(2048, 0, 1, 110, 0);
        run_phase(3300, 1, 6000, 110, 0);
        // disabled stretch in the middle of a poll
        push_simple(OP_SETTLE, 0, 0);
        push_write(CFG_ENABLE, 0);
        random_reads(20, 0);
        push_simple(OP_SETTLE, 0, 0);
        push_write(CFG_ENABLE, 1);

        // no idling; a long receiver hold-off to back the block up
        push_simple(OP_PACE, 0, 0);
        run_phase(4095, 1, 3300, 110, 80);
        push_simple(OP_SETTLE, 0, 0);
        push_simple(OP_HOLD, 0, 0);
        random_reads(150, 30);
        run_phase($urandom_range(4095), $urandom_range(7), $urandom_range(5000), 110, 20);
        run_phase($urandom_range(4095), $urandom_range(7), $urandom_range(16383), 110, 20);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (step_q.size() > 0 || in_valid || settling || settle_left > 0)
            @(negedge clk);
        waited = 0;
        while (due_readings.size() > 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_GAP) @(negedge clk);
        if (due_readings.size() > 0)
            flag_mismatch("results never delivered", due_readings.size(), 0);

        if (mismatches == 0)
            $display("battery_median_soc_monitor verification clean");
        else
            $display("battery_median_soc_monitor verification failed");
        $finish;
    end

endmodule

>>> battery_median_soc_monitor.f
rtl/bmsoc_pkg.sv
rtl/bmsoc_cell.sv
rtl/bmsoc_sorter.sv
rtl/bmsoc_scale.sv
rtl/battery_median_soc_monitor.sv
tb/sv/tb.sv
